@@ design/fcr_pkg.sv @@
// fcr_pkg: shared constants and types for the framed command responder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcr_pkg;
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_SPEED  = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [7:0] T_CMD   = 8'h10;
  localparam logic [7:0] T_REQ   = 8'h20;
  localparam logic [7:0] T_RSP   = 8'h40;
  localparam logic [7:0] T_CUR   = 8'h80;
  localparam logic [7:0] T_MASK  = 8'h0F;
  localparam logic [7:0] T_TIME  = 8'h01;
  localparam logic [7:0] T_SPEED = 8'h02;
  localparam logic [7:0] T_LOAD  = 8'h04;

  localparam logic [7:0] E_DIR = 8'h01;
  localparam logic [7:0] E_CNT = 8'h02;
  localparam logic [7:0] E_L0  = 8'h04;
  localparam logic [7:0] E_L1  = 8'h08;

  localparam logic [7:0] START_RESET = 8'hF0;
  localparam logic [7:0] END_RESET   = 8'h0E;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  // byte source selected by the controller
  typedef enum logic [2:0] {
    SRC_START, SRC_TYPE, SRC_LEN, SRC_TIME, SRC_SPEED, SRC_ERR, SRC_LOAD, SRC_HIST
  } src_e;

  typedef struct packed {
    src_e       src;
    logic [1:0] byte_sel;
    logic [1:0] load_sel;
    logic       hist_speed;
    logic       last;
  } emit_t;

  typedef struct packed {
    logic [7:0] ftype;
  } frame_t;
endpackage
`default_nettype wire

@@ design/fcr_if.sv @@
// fcr_in_if / fcr_out_if: valid-ready channels for input items and response words.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface fcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  rx_byte;
  logic [31:0] sample_time;
  logic [31:0] speed_bits;
  logic signed [31:0] load_a;
  logic signed [31:0] load_b;
  logic signed [31:0] load_c;
  logic signed [31:0] load_d;
  logic        count_error;
  logic        direction_change;
  logic        cell0_error;
  logic        cell1_error;
  modport source (output valid, cmd, rx_byte, sample_time, speed_bits, load_a, load_b,
                  load_c, load_d, count_error, direction_change, cell0_error,
                  cell1_error, input ready);
  modport sink (input valid, cmd, rx_byte, sample_time, speed_bits, load_a, load_b,
                load_c, load_d, count_error, direction_change, cell0_error,
                cell1_error, output ready);
endinterface

interface fcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_last;
  modport source (output valid, tx_byte, frame_last, input ready);
  modport sink (input valid, tx_byte, frame_last, output ready);
endinterface
`default_nettype wire

@@ design/fcr_ram.sv @@
// fcr_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fcr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ design/fcr_datapath.sv @@
// fcr_datapath: sample, load and error registers, history RAM and output byte mux.
// Depends on fcr_pkg, fcr_ram.
`timescale 1ns / 1ps
`default_nettype none
module fcr_datapath #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  smp_we_i,
  input  wire logic                  load_we_i,
  input  wire logic [31:0]           sample_time_i,
  input  wire logic [31:0]           speed_bits_i,
  input  wire logic [127:0]          loads_i,
  input  wire logic                  count_error_i,
  input  wire logic                  direction_change_i,
  input  wire logic [1:0]            cell_err_i,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] raddr_i,
  input  wire logic                  clr_sticky_i,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] clr_addr_i,
  input  wire logic                  clr_we_i,
  input  wire fcr_pkg::emit_t        emit_i,
  input  wire fcr_pkg::frame_t       frame_i,
  input  wire logic [7:0]            len_i,
  input  wire logic [7:0]            start_code_i,
  input  wire logic [7:0]            end_code_i,
  output logic [7:0]                 byte_o
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  logic [31:0]  time_q, speed_q;
  logic [127:0] loads_q;
  logic         cnt_q, dir_q;
  logic [1:0]   cell_q;
  logic [AW-1:0] widx_q;
  logic [63:0]  rdata;
  logic [AW-1:0] waddr;
  logic [63:0]  wdata;
  logic [7:0]   err;
  logic [31:0]  word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0; speed_q <= '0; loads_q <= '0;
      cnt_q <= 1'b0; dir_q <= 1'b0; cell_q <= 2'b11; widx_q <= '0;
    end else begin
      if (smp_we_i) begin
        time_q  <= sample_time_i;
        speed_q <= speed_bits_i;
        widx_q  <= (widx_q == AW'(HISTORY_DEPTH - 1)) ? '0 : widx_q + 1'b1;
      end
      if (clr_sticky_i) begin
        cnt_q <= 1'b0; dir_q <= 1'b0;
      end else if (smp_we_i) begin
        cnt_q <= cnt_q | count_error_i;
        dir_q <= dir_q | direction_change_i;
      end
      if (load_we_i) begin
        loads_q <= loads_i;
        cell_q  <= cell_err_i;
      end
    end
  end

  assign waddr = clr_we_i ? clr_addr_i : widx_q;
  assign wdata = clr_we_i ? 64'd0 : {speed_bits_i, sample_time_i};

  fcr_ram #(.WIDTH(64), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk_i, .we_i(clr_we_i | smp_we_i), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i, .rdata_o(rdata)
  );

  always_comb begin
    err = (cnt_q ? fcr_pkg::E_CNT : 8'h00) | (dir_q ? fcr_pkg::E_DIR : 8'h00);
    if ((frame_i.ftype & fcr_pkg::T_LOAD) != 8'h00) begin
      if (cell_q[0]) err = err | fcr_pkg::E_L0;
      if (cell_q[1]) err = err | fcr_pkg::E_L1;
    end
    case (emit_i.src)
      fcr_pkg::SRC_TIME:  word = time_q;
      fcr_pkg::SRC_SPEED: word = speed_q;
      fcr_pkg::SRC_LOAD:  word = loads_q[emit_i.load_sel*32 +: 32];
      fcr_pkg::SRC_HIST:  word = emit_i.hist_speed ? rdata[63:32] : rdata[31:0];
      default:            word = 32'd0;
    endcase
    if (emit_i.last) byte_o = end_code_i;
    else begin
      case (emit_i.src)
        fcr_pkg::SRC_START: byte_o = start_code_i;
        fcr_pkg::SRC_TYPE:
          byte_o = (frame_i.ftype & (fcr_pkg::T_REQ | fcr_pkg::T_CUR | fcr_pkg::T_MASK))
                   | fcr_pkg::T_RSP;
        fcr_pkg::SRC_LEN:   byte_o = len_i;
        fcr_pkg::SRC_ERR:   byte_o = err;
        default:            byte_o = word[emit_i.byte_sel*8 +: 8];
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/fcr_ctrl.sv @@
// fcr_ctrl: frame parser and response sequencer.
// Depends on fcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcr_ctrl #(
  parameter int HISTORY_DEPTH = 1024,
  parameter int FRAME_BYTES   = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [7:0] start_code_i,
  input  wire logic [7:0] end_code_i,
  output logic            in_ready_o,
  output logic            smp_we_o,
  output logic            load_we_o,
  output logic [$clog2(HISTORY_DEPTH)-1:0] raddr_o,
  output logic            clr_sticky_o,
  output logic [$clog2(HISTORY_DEPTH)-1:0] clr_addr_o,
  output logic            clr_we_o,
  output fcr_pkg::emit_t  emit_o,
  output fcr_pkg::frame_t frame_o,
  output logic [7:0]      len_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int PAY = FRAME_BYTES - 4;
  localparam logic [2:0] PH_WAIT = 3'd0, PH_TYPE = 3'd1, PH_LEN = 3'd2,
                         PH_DATA = 3'd3, PH_END = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_FETCH = 3'd2, S_EMIT = 3'd3;

  logic [2:0] st_q, st_d, ph_q, ph_d;
  logic [7:0] ftype_q, ftype_d, left_q, left_d, asked_q, asked_d;
  logic       first_q, first_d;
  logic [AW-1:0] ridx_q, ridx_d, clr_q;
  fcr_pkg::emit_t e_q, e_d;
  logic [7:0] recs_q, recs_d, len_q, len_d;
  logic [4:0] size;
  logic [7:0] cap, recs;
  logic       tt, ts, tl, acc, ob, hist;
  logic [7:0] wait_sz;

  assign tt = ftype_q[0];
  assign ts = ftype_q[1];
  assign tl = ftype_q[2];
  assign hist = !ftype_q[7];
  assign size = (tt ? 5'd4 : 5'd0) + (ts ? 5'd4 : 5'd0) + (tl ? 5'd16 : 5'd0);
  assign wait_sz = 8'd0;

  // record cap is one of five record sizes; small table
  always_comb begin
    case (size)
      5'd4:    cap = 8'(PAY / 4);
      5'd8:    cap = 8'(PAY / 8);
      5'd16:   cap = 8'(PAY / 16);
      5'd20:   cap = 8'(PAY / 20);
      5'd24:   cap = 8'(PAY / 24);
      default: cap = 8'd0;
    endcase
    recs = (asked_q < cap) ? asked_q : cap;
  end

  assign in_ready_o = (st_q == S_IDLE);
  assign acc = in_valid_i && in_ready_o;
  assign ob = out_valid_o && out_ready_i;
  assign out_valid_o = (st_q == S_EMIT);
  assign smp_we_o = acc && cmd_i == fcr_pkg::CMD_SPEED;
  assign load_we_o = acc && cmd_i == fcr_pkg::CMD_LOAD;
  assign clr_we_o = (st_q == S_CLEAR);
  assign clr_addr_o = clr_q;
  assign raddr_o = ridx_q;
  assign emit_o = e_q;
  assign len_o = len_q;
  assign frame_o = '{ftype: ftype_q};
  assign clr_sticky_o = ob && e_q.src == fcr_pkg::SRC_ERR && !e_q.last;

  always_comb begin
    st_d = st_q; ph_d = ph_q; ftype_d = ftype_q; left_d = left_q; asked_d = asked_q;
    first_d = first_q; ridx_d = ridx_q; e_d = e_q; recs_d = recs_q; len_d = len_q;
    unique case (st_q)
      S_CLEAR: if (clr_q == AW'(HISTORY_DEPTH - 1)) st_d = S_IDLE;
      S_IDLE: begin
        if (acc && cmd_i == fcr_pkg::CMD_BYTE) begin
          unique case (ph_q)
            PH_TYPE: begin
              if ((rx_byte_i & fcr_pkg::T_CMD) != 8'h00) begin
                ftype_d = rx_byte_i; ph_d = PH_LEN;
              end else ph_d = PH_WAIT;
            end
            PH_LEN: begin
              left_d = rx_byte_i; asked_d = 8'd0; first_d = 1'b1;
              ph_d = (rx_byte_i == 8'd0) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
              if (first_q) begin
                asked_d = rx_byte_i; first_d = 1'b0;
              end
              left_d = left_q - 8'd1;
              if (left_q == 8'd1) ph_d = PH_END;
            end
            PH_END: begin
              if (rx_byte_i == end_code_i) begin
                ph_d = PH_WAIT;
                if ((ftype_q & fcr_pkg::T_REQ) != 8'h00) begin
                  st_d = S_EMIT;
                  e_d = '{src: fcr_pkg::SRC_START, byte_sel: 2'd0, load_sel: 2'd0,
                          hist_speed: 1'b0, last: 1'b0};
                  if (hist) begin
                    recs_d = recs;
                    len_d = 8'(size * recs);
                  end else begin
                    recs_d = 8'd0;
                    len_d = (tt ? 8'd4 : 8'd0) + (ts ? 8'd5 : 8'd0) + (tl ? 8'd16 : 8'd0);
                  end
                end
              end else ph_d = (rx_byte_i == start_code_i) ? PH_TYPE : PH_WAIT;
            end
            default: ph_d = (rx_byte_i == start_code_i) ? PH_TYPE : PH_WAIT;
          endcase
        end
      end
      S_FETCH: st_d = S_EMIT;
      S_EMIT: begin
        if (ob) begin
          // next byte of the response; words step through byte_sel
          if (e_q.last) st_d = S_IDLE;
          else if ((e_q.src == fcr_pkg::SRC_TIME || e_q.src == fcr_pkg::SRC_SPEED ||
                    e_q.src == fcr_pkg::SRC_LOAD || e_q.src == fcr_pkg::SRC_HIST) &&
                   e_q.byte_sel != 2'd3) begin
            e_d.byte_sel = e_q.byte_sel + 2'd1;
          end else begin
            e_d.byte_sel = 2'd0;
            unique case (e_q.src)
              fcr_pkg::SRC_START: e_d.src = fcr_pkg::SRC_TYPE;
              fcr_pkg::SRC_TYPE:  e_d.src = fcr_pkg::SRC_LEN;
              fcr_pkg::SRC_LEN: begin
                if (hist) begin
                  if (recs_q == 8'd0) e_d.last = 1'b1;
                  else begin
                    st_d = S_FETCH;
                    if (tt) begin
                      e_d.src = fcr_pkg::SRC_HIST; e_d.hist_speed = 1'b0;
                    end else if (ts) begin
                      e_d.src = fcr_pkg::SRC_HIST; e_d.hist_speed = 1'b1;
                    end else begin
                      e_d.src = fcr_pkg::SRC_LOAD; e_d.load_sel = 2'd0;
                    end
                  end
                end else if (tt) e_d.src = fcr_pkg::SRC_TIME;
                else if (ts) e_d.src = fcr_pkg::SRC_SPEED;
                else if (tl) begin
                  e_d.src = fcr_pkg::SRC_LOAD; e_d.load_sel = 2'd0;
                end else e_d.last = 1'b1;
              end
              fcr_pkg::SRC_TIME: begin
                if (ts) e_d.src = fcr_pkg::SRC_SPEED;
                else if (tl) begin
                  e_d.src = fcr_pkg::SRC_LOAD; e_d.load_sel = 2'd0;
                end else e_d.last = 1'b1;
              end
              fcr_pkg::SRC_SPEED: e_d.src = fcr_pkg::SRC_ERR;
              fcr_pkg::SRC_ERR: begin
                if (tl) begin
                  e_d.src = fcr_pkg::SRC_LOAD; e_d.load_sel = 2'd0;
                end else e_d.last = 1'b1;
              end
              fcr_pkg::SRC_HIST: begin
                if (!e_q.hist_speed && ts) e_d.hist_speed = 1'b1;
                else if (tl) begin
                  e_d.src = fcr_pkg::SRC_LOAD; e_d.load_sel = 2'd0;
                end else begin
                  // record done
                  ridx_d = (ridx_q == AW'(HISTORY_DEPTH - 1)) ? '0 : ridx_q + 1'b1;
                  recs_d = recs_q - 8'd1;
                  if (recs_q == 8'd1) e_d.last = 1'b1;
                  else begin
                    st_d = S_FETCH; e_d.hist_speed = !tt;
                  end
                end
              end
              fcr_pkg::SRC_LOAD: begin
                if (e_q.load_sel != 2'd3) e_d.load_sel = e_q.load_sel + 2'd1;
                else if (!hist) e_d.last = 1'b1;
                else begin
                  ridx_d = (ridx_q == AW'(HISTORY_DEPTH - 1)) ? '0 : ridx_q + 1'b1;
                  recs_d = recs_q - 8'd1;
                  if (recs_q == 8'd1) e_d.last = 1'b1;
                  else begin
                    st_d = S_FETCH;
                    if (tt || ts) begin
                      e_d.src = fcr_pkg::SRC_HIST; e_d.hist_speed = !tt;
                    end else e_d.load_sel = 2'd0;
                  end
                end
              end
              default: e_d.last = 1'b1;
            endcase
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR; ph_q <= PH_WAIT; ftype_q <= '0; left_q <= '0; asked_q <= '0;
      first_q <= 1'b0; ridx_q <= '0; clr_q <= '0; recs_q <= '0; len_q <= '0;
      e_q <= '{src: fcr_pkg::SRC_START, byte_sel: 2'd0, load_sel: 2'd0,
               hist_speed: 1'b0, last: 1'b0};
    end else begin
      st_q <= st_d; ph_q <= ph_d; ftype_q <= ftype_d; left_q <= left_d;
      asked_q <= asked_d; first_q <= first_d; ridx_q <= ridx_d; recs_q <= recs_d;
      len_q <= len_d; e_q <= e_d;
      if (st_q == S_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during response");
  a_fetch_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_FETCH |=> out_valid_o) else $error("fetch not followed by emit");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ob && e_q.last) |=> in_ready_o) else $error("no return to idle after end word");
  a_recs_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hist && e_q.src == fcr_pkg::SRC_LEN) |-> len_q <= 8'(PAY) + wait_sz)
    else $error("history payload over cap");
endmodule
`default_nettype wire

@@ design/framed_command_responder.sv @@
// framed_command_responder: top level, joins parser/sequencer and datapath.
// Depends on fcr_pkg, fcr_if, fcr_ctrl, fcr_datapath.
//
// Input channel in_if carries one item per handshake: a received link byte
// (cmd 0), a speed sample (cmd 1) or load readings (cmd 2). Bytes are parsed
// as start, type, length, data, end frames. A closing end byte of a request
// frame starts a response on out_if, one byte per cycle while the receiver
// is ready, with a fetch state before each history record for the RAM read;
// a history response is up to FRAME_BYTES bytes. While a response is going
// out the input is not ready; a stalled receiver just holds the byte. After
// reset the history RAM is cleared, one entry per cycle, before the first
// item is taken; configuration writes (start and end code) are taken at any
// time.
`timescale 1ns / 1ps
`default_nettype none
module framed_command_responder #(
  parameter int HISTORY_DEPTH = 1024,
  parameter int FRAME_BYTES   = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  fcr_in_if.sink          in_if,
  fcr_out_if.source       out_if,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  logic [7:0] start_q, end_q;
  logic smp_we, load_we, clr_sticky, clr_we;
  logic [AW-1:0] raddr, clr_addr;
  fcr_pkg::emit_t emit;
  fcr_pkg::frame_t frame;
  logic [7:0] len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= fcr_pkg::START_RESET; end_q <= fcr_pkg::END_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fcr_pkg::CFG_START) start_q <= cfg_data_i;
      else end_q <= cfg_data_i;
    end
  end

  fcr_ctrl #(.HISTORY_DEPTH(HISTORY_DEPTH), .FRAME_BYTES(FRAME_BYTES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .cmd_i(in_if.cmd), .rx_byte_i(in_if.rx_byte),
    .start_code_i(start_q), .end_code_i(end_q), .in_ready_o(in_if.ready),
    .smp_we_o(smp_we), .load_we_o(load_we), .raddr_o(raddr), .clr_sticky_o(clr_sticky),
    .clr_addr_o(clr_addr), .clr_we_o(clr_we), .emit_o(emit), .frame_o(frame),
    .len_o(len), .out_valid_o(out_if.valid), .out_ready_i(out_if.ready)
  );

  fcr_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk_i, .rst_ni, .smp_we_i(smp_we), .load_we_i(load_we),
    .sample_time_i(in_if.sample_time), .speed_bits_i(in_if.speed_bits),
    .loads_i({in_if.load_d, in_if.load_c, in_if.load_b, in_if.load_a}),
    .count_error_i(in_if.count_error), .direction_change_i(in_if.direction_change),
    .cell_err_i({in_if.cell1_error, in_if.cell0_error}), .raddr_i(raddr),
    .clr_sticky_i(clr_sticky), .clr_addr_i(clr_addr), .clr_we_i(clr_we),
    .emit_i(emit), .frame_i(frame), .len_i(len), .start_code_i(start_q),
    .end_code_i(end_q), .byte_o(out_if.tx_byte)
  );

  assign out_if.frame_last = emit.last;
endmodule
`default_nettype wire
